// ===== rtl/vfd_pkg.sv =====
// Shared constants and types for the order-2 ADPCM frame decoder.
`default_nettype none

package vfd_pkg;

    localparam int CODEBOOK_WORDS = 128;
    localparam int CB_AW          = $clog2(CODEBOOK_WORDS);
    // row (4 bits) times 16 plus position (4 bits)
    localparam int CB_ADDR_W      = 8;
    localparam int SAMPLE_W       = 16;
    localparam int PROD_W         = 2 * SAMPLE_W;
    localparam int ACC_W          = 36;
    localparam int FRAC_SHIFT     = 11;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    localparam logic MODE_COEF = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic init;   // load accumulator with the bias term
        logic valid;  // coefficient and operand carry a product term
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/vfd_mac.sv =====
// Shared multiply-accumulate unit with floor shift and saturation.
`default_nettype none

module vfd_mac
    import vfd_pkg::*;
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  mac_ctrl_t                         ctrl,
    input  wire logic signed [ACC_W-1:0]      init_value,
    input  wire logic signed [SAMPLE_W-1:0]   coef,
    input  wire logic signed [SAMPLE_W-1:0]   operand,
    output logic                              busy,
    output logic signed [SAMPLE_W-1:0]        result
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     pv_reg;
    logic                     pv_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  shifted;

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.valid)
        begin
            prod_next = coef * operand;
        end
        pv_next = ctrl.valid;

        acc_next = acc_reg;
        if (ctrl.init)
        begin
            acc_next = init_value;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // floor by 2^11, then clamp to 16 bits
    always_comb
    begin
        shifted = acc_reg >>> FRAC_SHIFT;
        if (shifted > SAT_MAX)
        begin
            result = SAMPLE_W'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            result = SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            result = SAMPLE_W'(shifted);
        end
    end

    assign busy = pv_reg;

endmodule

`default_nettype wire

// ===== rtl/vadpcm_frame_decoder.sv =====
// Top level of the order-2 ADPCM frame decoder: stream handling, sequencer, codebook.
//
//  channel  dir  fields (tdata / tuser / tlast)                           per word
//  s_axis   in   tdata: coef_index, coef_value, data_byte; tuser: mode,   one byte
//                restart                                                  or coef
//  m_axis   out  tdata: sample, sample_position; tlast: last              one sample
//
//  A coefficient write or a header byte is taken in idle. A data byte at group index k
//  (0, 2, 4, 6) yields two samples; each sample issues one product term per cycle on the
//  single multiplier and codebook read port, after a setup step and followed by
//  pipeline drain and result load. A stalled output holds the sequencer in
//  its result-load step. Reset clears history, frame position and the handshake
//  state; the codebook holds no reset value and must be written before use.
`default_nettype none

module vadpcm_frame_decoder
    import vfd_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] coef_index, [22:7] coef_value, [30:23] data_byte, [31] zero
    input  wire  [31:0] s_axis_tdata,
    // [0] mode, [1] restart
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] sample, [19:16] sample_position, [23:20] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } vfd_state_t;

    function automatic logic signed [SAMPLE_W-1:0] scale_nib(logic [3:0] n, logic [3:0] sh);
        logic signed [SAMPLE_W-1:0] ext;
        ext = {{(SAMPLE_W-4){n[3]}}, n};
        return ext <<< sh;
    endfunction

    // input word fields
    logic                   in_mode;
    logic                   in_restart;
    logic [6:0]             in_index;
    logic [SAMPLE_W-1:0]    in_coef;
    logic [7:0]             in_byte;
    logic                   in_acc;

    assign in_mode    = s_axis_tuser[0];
    assign in_restart = s_axis_tuser[1];
    assign in_index   = s_axis_tdata[6:0];
    assign in_coef    = s_axis_tdata[22:7];
    assign in_byte    = s_axis_tdata[30:23];

    vfd_state_t                  st_reg, st_next;
    logic [3:0]                  fp_reg, fp_next;
    logic [3:0]                  shift_reg, shift_next;
    logic [3:0]                  row_reg, row_next;
    logic signed [SAMPLE_W-1:0]  h0_reg, h0_next;
    logic signed [SAMPLE_W-1:0]  h1_reg, h1_next;
    logic signed [SAMPLE_W-1:0]  g_reg [8];
    logic signed [SAMPLE_W-1:0]  g_next [8];
    logic [2:0]                  k_reg, k_next;
    logic [2:0]                  pos_reg, pos_next;
    logic                        sel_reg, sel_next;
    logic [3:0]                  t_reg, t_next;
    logic signed [SAMPLE_W-1:0]  s0_reg, s0_next;
    logic                        issue_v_reg;
    logic signed [SAMPLE_W-1:0]  b_reg;
    logic signed [SAMPLE_W-1:0]  rd_data_reg;
    logic                        rd_zero_reg;
    logic                        out_v_reg, out_v_next;
    logic signed [SAMPLE_W-1:0]  out_s_reg, out_s_next;
    logic [3:0]                  out_p_reg, out_p_next;
    logic                        out_l_reg, out_l_next;

    logic signed [SAMPLE_W-1:0]  cb_mem [CODEBOOK_WORDS];

    logic [3:0]                  fp_eff;
    logic [2:0]                  pos_in;
    logic [2:0]                  k_in;
    logic [2:0]                  m;
    logic [2:0]                  j;
    logic [3:0]                  pos4;
    logic [CB_ADDR_W-1:0]        rd_addr;
    logic signed [SAMPLE_W-1:0]  b_sel;
    logic                        last_term;
    logic                        out_free;

    mac_ctrl_t                   mac_ctrl;
    logic signed [ACC_W-1:0]     mac_init;
    logic signed [SAMPLE_W-1:0]  mac_coef;
    logic                        mac_busy;
    logic signed [SAMPLE_W-1:0]  mac_result;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign fp_eff = in_restart ? 4'd0 : fp_reg;
    assign pos_in = 3'(fp_eff - 4'd1);
    assign k_in   = {pos_in[1:0], 1'b0};
    assign m      = k_reg + {2'b00, sel_reg};
    assign j      = 3'(t_reg - 4'd2);

    // term 0: history[0], term 1: history[1], then earlier nibbles of the group
    always_comb
    begin
        if (t_reg == 4'd0)
        begin
            pos4  = {1'b0, m};
            b_sel = h0_reg;
        end
        else if (t_reg == 4'd1)
        begin
            pos4  = {1'b1, m};
            b_sel = h1_reg;
        end
        else
        begin
            pos4  = {1'b1, j};
            b_sel = g_reg[3'(m - 3'd1 - j)];
        end
    end

    assign rd_addr   = {row_reg, pos4};
    assign last_term = (t_reg == ({1'b0, m} + 4'd1));
    assign out_free  = !out_v_reg || m_axis_tready;

    assign mac_ctrl.init  = (st_reg == ST_SETUP);
    assign mac_ctrl.valid = issue_v_reg;
    assign mac_init       = ACC_W'(g_reg[m]) <<< FRAC_SHIFT;
    assign mac_coef       = rd_zero_reg ? '0 : rd_data_reg;

    vfd_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .init_value (mac_init),
        .coef       (mac_coef),
        .operand    (b_reg),
        .busy       (mac_busy),
        .result     (mac_result)
    );

    always_comb
    begin
        st_next    = st_reg;
        fp_next    = fp_reg;
        shift_next = shift_reg;
        row_next   = row_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        g_next     = g_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        t_next     = t_reg;
        s0_next    = s0_reg;
        out_v_next = out_v_reg;
        out_s_next = out_s_reg;
        out_p_next = out_p_reg;
        out_l_next = out_l_reg;

        if (out_v_reg && m_axis_tready)
        begin
            out_v_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_restart)
                    begin
                        fp_next = 4'd0;
                        h0_next = '0;
                        h1_next = '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            g_next[i] = '0;
                        end
                    end
                    if (in_mode == MODE_DATA)
                    begin
                        if (fp_eff == 4'd0 || fp_eff > 4'd8)
                        begin
                            shift_next = in_byte[7:4];
                            row_next   = in_byte[3:0];
                            fp_next    = 4'd1;
                        end
                        else
                        begin
                            g_next[k_in]         = scale_nib(in_byte[7:4], shift_reg);
                            g_next[k_in + 3'd1]  = scale_nib(in_byte[3:0], shift_reg);
                            k_next   = k_in;
                            pos_next = pos_in;
                            sel_next = 1'b0;
                            fp_next  = (fp_eff >= 4'd8) ? 4'd0 : fp_eff + 4'd1;
                            st_next  = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP:
            begin
                t_next  = 4'd0;
                st_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                t_next = t_reg + 4'd1;
                if (last_term)
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!issue_v_reg && !mac_busy)
                begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output slot frees
                if (out_free)
                begin
                    out_v_next = 1'b1;
                    out_s_next = mac_result;
                    out_p_next = {pos_reg, sel_reg};
                    out_l_next = sel_reg;
                    if (!sel_reg)
                    begin
                        s0_next  = mac_result;
                        sel_next = 1'b1;
                        st_next  = ST_SETUP;
                    end
                    else
                    begin
                        if (k_reg == 3'd6)
                        begin
                            h0_next = s0_reg;
                            h1_next = mac_result;
                        end
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            fp_reg      <= '0;
            shift_reg   <= '0;
            row_reg     <= '0;
            h0_reg      <= '0;
            h1_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                g_reg[i] <= '0;
            end
            sel_reg     <= 1'b0;
            t_reg       <= '0;
            issue_v_reg <= 1'b0;
            rd_zero_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            fp_reg      <= fp_next;
            shift_reg   <= shift_next;
            row_reg     <= row_next;
            h0_reg      <= h0_next;
            h1_reg      <= h1_next;
            g_reg       <= g_next;
            sel_reg     <= sel_next;
            t_reg       <= t_next;
            issue_v_reg <= (st_reg == ST_ISSUE);
            rd_zero_reg <= (rd_addr >= CB_ADDR_W'(CODEBOOK_WORDS));
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        s0_reg    <= s0_next;
        b_reg     <= b_sel;
        out_s_reg <= out_s_next;
        out_p_reg <= out_p_next;
        out_l_reg <= out_l_next;
    end

    // codebook: one write port in idle, one registered read port for the sequencer
    always_ff @(posedge clk)
    begin
        if (in_acc && in_mode == MODE_COEF
            && ({1'b0, in_index} < CB_ADDR_W'(CODEBOOK_WORDS)))
        begin
            cb_mem[in_index[CB_AW-1:0]] <= in_coef;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= cb_mem[rd_addr[CB_AW-1:0]];
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {4'b0000, out_p_reg, out_s_reg};
    assign m_axis_tlast  = out_l_reg;

endmodule

`default_nettype wire
